>>> hw/rtl/tbs_pkg.sv
// ----------------------------------------------------------------------------
// tbs_pkg - shared types and constants for the barycentric solver
// Item layouts of both channels, status codes and pipeline depths.
// ----------------------------------------------------------------------------
package tbs_pkg;

	// one input item: three vertices and the query point, signed Q2.30
	typedef struct packed {
		logic signed [31:0] v1_x;
		logic signed [31:0] v1_y;
		logic signed [31:0] v1_z;
		logic signed [31:0] v2_x;
		logic signed [31:0] v2_y;
		logic signed [31:0] v2_z;
		logic signed [31:0] v3_x;
		logic signed [31:0] v3_y;
		logic signed [31:0] v3_z;
		logic signed [31:0] query_x;
		logic signed [31:0] query_y;
		logic signed [31:0] query_z;
	} tri_item_t;

	// one result item
	typedef struct packed {
		logic signed [31:0] weight_a;
		logic signed [31:0] weight_b;
		logic signed [31:0] weight_c;
		logic [1:0]         status;
	} wgt_item_t;

	// what one divider lane hands to the merge stage
	typedef struct packed {
		logic [31:0] weight;
		logic        sat;
		logic        den_zero;
	} lane_res_t;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_SINGULAR  = 2'd1;
	localparam logic [1:0] STATUS_SATURATED = 2'd2;

	// quotient bits resolved by the divider; larger quotients saturate anyway
	localparam int QUO_BITS   = 33;
	localparam int DET_STAGES = 4;
	localparam int DIV_STAGES = 3 + QUO_BITS;

	localparam logic [31:0] WEIGHT_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] WEIGHT_MIN = 32'h8000_0000;

endpackage

>>> hw/rtl/tbs_det3.sv
// ----------------------------------------------------------------------------
// tbs_det3 - pipelined exact 3x3 determinant
// Columns c0, c1, c2; four register stages: products, minors, split
// cofactor products, final sum.
// ----------------------------------------------------------------------------
module tbs_det3 #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic signed [COORD_WIDTH-1:0]  col [0:2][0:2],
	output logic signed [3*COORD_WIDTH+2:0] det
);
	localparam int W  = COORD_WIDTH;
	localparam int MW = 2 * W + 1;
	localparam int PW = 2 * W + 1;
	localparam int DW = 3 * W + 3;

	logic signed [2*W-1:0] pa_s1 [0:2];
	logic signed [2*W-1:0] pb_s1 [0:2];
	logic signed [W-1:0]   x_s1  [0:2];
	logic signed [MW-1:0]  m_s2  [0:2];
	logic signed [W-1:0]   x_s2  [0:2];
	logic signed [PW-1:0]  lo_s3 [0:2];
	logic signed [PW-1:0]  hi_s3 [0:2];
	logic signed [DW-1:0]  term  [0:2];
	logic signed [DW-1:0]  det_s4;

	// stage 1: the six products of the 2x2 minors
	always_ff @(posedge clk) begin
		if (en) begin
			pa_s1[0] <= col[1][1] * col[2][2];
			pb_s1[0] <= col[2][1] * col[1][2];
			pa_s1[1] <= col[0][1] * col[2][2];
			pb_s1[1] <= col[2][1] * col[0][2];
			pa_s1[2] <= col[0][1] * col[1][2];
			pb_s1[2] <= col[1][1] * col[0][2];
			x_s1[0]  <= col[0][0];
			x_s1[1]  <= col[1][0];
			x_s1[2]  <= col[2][0];
		end
	end

	// stage 2: minors
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				m_s2[k] <= MW'(pa_s1[k]) - MW'(pb_s1[k]);
				x_s2[k] <= x_s1[k];
			end
		end
	end

	// stage 3: cofactor times minor, minor split into low and high halves
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				lo_s3[k] <= x_s2[k] * $signed({1'b0, m_s2[k][W-1:0]});
				hi_s3[k] <= x_s2[k] * $signed(m_s2[k][MW-1:W]);
			end
		end
	end

	// stage 4: recombine halves and sum with cofactor signs
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			term[k] = (DW'(hi_s3[k]) <<< W) + DW'(lo_s3[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det_s4 <= term[0] - term[1] + term[2];
		end
	end

	assign det = det_s4;

endmodule

>>> hw/rtl/tbs_div.sv
// ----------------------------------------------------------------------------
// tbs_div - pipelined rounding divider with saturation
// Computes round(num * 2^F / den), half away from zero, clamped to a
// signed 32-bit weight. One restoring step per stage.
// ----------------------------------------------------------------------------
module tbs_div #(
	parameter int COORD_WIDTH      = 32,
	parameter int WEIGHT_FRAC_BITS = 24
) (
	input  logic                            clk,
	input  logic                            en,
	input  logic signed [3*COORD_WIDTH+2:0] num,
	input  logic signed [3*COORD_WIDTH+2:0] den,
	output tbs_pkg::lane_res_t              res
);
	localparam int DW = 3 * COORD_WIDTH + 3;
	localparam int F  = WEIGHT_FRAC_BITS;
	localparam int QB = tbs_pkg::QUO_BITS;
	localparam int AW = DW + F + 2;
	localparam int RW = (AW > DW + QB + 2) ? AW : DW + QB + 2;

	logic [DW-1:0] absn_s0, absd_s0;
	logic          neg_s0, zero_s0;
	logic [RW-1:0] a_s1, b_s1;
	logic          neg_s1, zero_s1;

	// per-step pipeline: entry 0 is the stage 2 state
	logic [RW-1:0] rem_st  [0:QB];
	logic [RW-1:0] b_st    [0:QB];
	logic [QB-1:0] q_st    [0:QB];
	logic          ovf_st  [0:QB];
	logic          neg_st  [0:QB];
	logic          zero_st [0:QB];

	logic [QB-1:0] q_fin, lim;
	logic          sat;

	// stage 0: magnitudes and sign of the quotient
	always_ff @(posedge clk) begin
		if (en) begin
			absn_s0 <= num[DW-1] ? (~num + 1'b1) : num;
			absd_s0 <= den[DW-1] ? (~den + 1'b1) : den;
			neg_s0  <= num[DW-1] ^ den[DW-1];
			zero_s0 <= (den == '0);
		end
	end

	// stage 1: dividend 2*m*2^F + d and divisor 2*d for rounding
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1    <= (RW'(absn_s0) << (F + 1)) + RW'(absd_s0);
			b_s1    <= RW'(absd_s0) << 1;
			neg_s1  <= neg_s0;
			zero_s1 <= zero_s0;
		end
	end

	// stage 2: quotient too large for the resolved bits saturates;
	// then restoring steps, most significant quotient bit first
	always_ff @(posedge clk) begin
		if (en) begin
			ovf_st[0]  <= (a_s1 >= (b_s1 << QB));
			rem_st[0]  <= a_s1;
			b_st[0]    <= b_s1;
			q_st[0]    <= '0;
			neg_st[0]  <= neg_s1;
			zero_st[0] <= zero_s1;
			for (int k = 0; k < QB; k++) begin
				if (rem_st[k] >= (b_st[k] << (QB - 1 - k))) begin
					rem_st[k+1] <= rem_st[k] - (b_st[k] << (QB - 1 - k));
					q_st[k+1]   <= {q_st[k][QB-2:0], 1'b1};
				end else begin
					rem_st[k+1] <= rem_st[k];
					q_st[k+1]   <= {q_st[k][QB-2:0], 1'b0};
				end
				b_st[k+1]    <= b_st[k];
				ovf_st[k+1]  <= ovf_st[k];
				neg_st[k+1]  <= neg_st[k];
				zero_st[k+1] <= zero_st[k];
			end
		end
	end

	// clamp and apply sign
	assign q_fin = q_st[QB];
	assign lim   = neg_st[QB] ? QB'(tbs_pkg::WEIGHT_MIN) : QB'(tbs_pkg::WEIGHT_MAX);
	assign sat   = ovf_st[QB] || (q_fin > lim);

	always_comb begin
		res.sat      = sat;
		res.den_zero = zero_st[QB];
		if (sat) begin
			res.weight = neg_st[QB] ? tbs_pkg::WEIGHT_MIN : tbs_pkg::WEIGHT_MAX;
		end else if (neg_st[QB]) begin
			res.weight = ~q_fin[31:0] + 32'd1;
		end else begin
			res.weight = q_fin[31:0];
		end
	end

endmodule

>>> hw/rtl/triangle_barycentric_solve.sv
// ----------------------------------------------------------------------------
// triangle_barycentric_solve - barycentric weights by Cramer's rule
// Four determinant lanes (system and three replaced-column numerators),
// three divider lanes, one merge stage building weights and status.
//
//   channel | dir | handshake            | item
//   tri     | in  | tri_valid, tri_stall | tbs_pkg::tri_item_t
//   wgt     | out | wgt_valid, wgt_stall | tbs_pkg::wgt_item_t
//
// One item per cycle while the output is not stalled; the pipeline is the
// determinant stages, one divider stage per quotient bit and the output register.
// Reset clears only the valid bits; there is no clearing pass.
// A stalled output freezes the whole pipeline; tri_stall follows it.
// ----------------------------------------------------------------------------
module triangle_barycentric_solve #(
	parameter int COORD_WIDTH      = 32,
	parameter int WEIGHT_FRAC_BITS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               tri_valid,
	output logic               tri_stall,
	input  tbs_pkg::tri_item_t tri_item,
	output logic               wgt_valid,
	input  logic               wgt_stall,
	output tbs_pkg::wgt_item_t wgt_item
);
	localparam int W   = COORD_WIDTH;
	localparam int DW  = 3 * W + 3;
	localparam int LAT = tbs_pkg::DET_STAGES + tbs_pkg::DIV_STAGES;

	logic [31:0]          raw      [0:3][0:2];
	logic signed [W-1:0]  coord    [0:3][0:2];
	logic signed [W-1:0]  lane_col [0:3][0:2][0:2];
	logic signed [DW-1:0] det      [0:3];
	tbs_pkg::lane_res_t   res      [0:2];

	logic [LAT-1:0]       vld_q;
	logic                 adv;
	logic                 out_vld_q;
	tbs_pkg::wgt_item_t   out_q;
	tbs_pkg::wgt_item_t   merged;

	// pipeline moves whenever the output register can take an item
	assign adv       = !(out_vld_q && wgt_stall);
	assign tri_stall = !adv;

	assign raw[0][0] = tri_item.v1_x;
	assign raw[0][1] = tri_item.v1_y;
	assign raw[0][2] = tri_item.v1_z;
	assign raw[1][0] = tri_item.v2_x;
	assign raw[1][1] = tri_item.v2_y;
	assign raw[1][2] = tri_item.v2_z;
	assign raw[2][0] = tri_item.v3_x;
	assign raw[2][1] = tri_item.v3_y;
	assign raw[2][2] = tri_item.v3_z;
	assign raw[3][0] = tri_item.query_x;
	assign raw[3][1] = tri_item.query_y;
	assign raw[3][2] = tri_item.query_z;

	// coordinates at the working width
	for (genvar v = 0; v < 4; v++) begin : g_vtx
		for (genvar j = 0; j < 3; j++) begin : g_cmp
			if (W <= 32) begin : g_cut
				assign coord[v][j] = $signed(raw[v][j][W-1:0]);
			end else begin : g_ext
				assign coord[v][j] = $signed({{(W-32){raw[v][j][31]}}, raw[v][j]});
			end
		end
	end

	// lane 0: system matrix; lane l: column l-1 replaced by the query point
	for (genvar l = 0; l < 4; l++) begin : g_lane
		for (genvar c = 0; c < 3; c++) begin : g_col
			for (genvar j = 0; j < 3; j++) begin : g_cmp
				assign lane_col[l][c][j] = (l != 0 && c == l - 1) ? coord[3][j]
				                                                  : coord[c][j];
			end
		end
		tbs_det3 #(
			.COORD_WIDTH (W)
		) u_det (
			.clk (clk),
			.en  (adv),
			.col (lane_col[l]),
			.det (det[l])
		);
	end

	// one divider per weight, all against the system determinant
	for (genvar l = 0; l < 3; l++) begin : g_div
		tbs_div #(
			.COORD_WIDTH      (W),
			.WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
		) u_div (
			.clk (clk),
			.en  (adv),
			.num (det[l+1]),
			.den (det[0]),
			.res (res[l])
		);
	end

	// merge: singular overrides everything, then saturation
	always_comb begin
		if (res[0].den_zero) begin
			merged.weight_a = '0;
			merged.weight_b = '0;
			merged.weight_c = '0;
			merged.status   = tbs_pkg::STATUS_SINGULAR;
		end else begin
			merged.weight_a = $signed(res[0].weight);
			merged.weight_b = $signed(res[1].weight);
			merged.weight_c = $signed(res[2].weight);
			merged.status   = (res[0].sat || res[1].sat || res[2].sat)
			                  ? tbs_pkg::STATUS_SATURATED : tbs_pkg::STATUS_OK;
		end
	end

	// item valid chain alongside the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_q     <= {vld_q[LAT-2:0], tri_valid};
			out_vld_q <= vld_q[LAT-1];
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= merged;
		end
	end

	assign wgt_valid = out_vld_q;
	assign wgt_item  = out_q;

endmodule
